// ----- sv/assert_macros.svh -----
// Assertion helper macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- sv/scc_pkg.sv -----
// -----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the strongly connected components block.
// -----------------------------------------------------------------------------
`default_nettype none
package scc_pkg;
   localparam int NumVertices = 32;
   localparam int VtxWidth    = 5;
   localparam int CntWidth    = 6;

   localparam logic [1:0] OpClear = 2'd0;
   localparam logic [1:0] OpAdd   = 2'd1;
   localparam logic [1:0] OpRun   = 2'd2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [4:0] source_vertex;
      logic [4:0] target_vertex;
   } req_type;

   typedef struct packed {
      logic [4:0] vertex;
      logic [4:0] component;
      logic       component_end;
      logic       last;
   } rsp_type;
endpackage
`default_nettype wire

// ----- sv/strongly_connected_components_top.sv -----
// -----------------------------------------------------------------------------
// strongly_connected_components_top
// Kosaraju SCC over a 32-vertex adjacency bit matrix held in RAM.
// -----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req_     in   req_valid/req_ready  scc_pkg::req_type
//  rsp_     out  rsp_valid/rsp_ready  scc_pkg::rsp_type
//  csr_     in   csr_wr_en            vertex_count, 6 bits
//
// Add edge holds the input while it runs: accept with both row reads, then write
// back. Clear holds it for the accept and then clears one row of the matrix and
// of its transpose per cycle. A run scans for roots in both passes and walks the
// graph with an explicit stack, pushing, popping and reloading stack entries.
// After reset a clearing pass over all 32 rows runs with req_ready low. A result
// waiting on rsp_ready stalls the second pass at its next vertex.
`default_nettype none
`include "assert_macros.svh"
module strongly_connected_components_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire scc_pkg::req_type  req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      scc_pkg::rsp_type  rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [5:0]        csr_wr_data
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLEAR = 4'd1;
   localparam logic [3:0] S_ADDWR = 4'd2;
   localparam logic [3:0] S_ROOT1 = 4'd3;
   localparam logic [3:0] S_STEP  = 4'd4;
   localparam logic [3:0] S_POP   = 4'd5;
   localparam logic [3:0] S_ROOT2 = 4'd6;
   localparam logic [3:0] S_RCHK  = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0]                     state_ff, state_in;
   logic [scc_pkg::CntWidth-1:0]   vcount_ff;
   logic [scc_pkg::CntWidth-1:0]   n;
   logic [scc_pkg::CntWidth-1:0]   ctr_ff, ctr_in;   // clear row / root index / finish index
   logic [scc_pkg::CntWidth-1:0]   sp_ff, sp_in;     // stack depth including the top
   logic [scc_pkg::CntWidth-1:0]   fc_ff, fc_in;     // finished vertices
   logic [scc_pkg::CntWidth-1:0]   top_j_ff, top_j_in;
   logic [scc_pkg::CntWidth-1:0]   found;
   logic [scc_pkg::VtxWidth-1:0]   top_v_ff, top_v_in;
   logic [scc_pkg::VtxWidth-1:0]   src_ff, src_in, dst_ff, dst_in;
   logic [scc_pkg::VtxWidth-1:0]   comp_ff, comp_in;
   logic                           pass2_ff, pass2_in;
   logic [31:0]                    visited_ff, visited_in;
   logic                           pv_ff, pv_in;     // pending result held for its flags
   scc_pkg::rsp_type               pend_ff, pend_in;
   logic                           rv_ff, rv_in;
   scc_pkg::rsp_type               rsp_ff, rsp_in;
   logic                           out_free, emit_ok;
   logic [31:0]                    live_mask, row, cand;

   // adjacency and transposed adjacency RAMs, written together
   logic        a_we;
   logic [4:0]  a_wa, a_ra, t_wa, t_ra;
   logic [31:0] a_wd, a_rd, t_wd, t_rd;
   // walk stack RAM below the top: {next index (6), vertex (5)}
   logic        s_we;
   logic [4:0]  s_wa, s_ra;
   logic [10:0] s_wd, s_rd;
   // finish order RAM
   logic        f_we;
   logic [4:0]  f_wa, f_ra;
   logic [4:0]  f_wd, f_rd;

   scc_ram #(.Width(32), .Depth(32)) u_adj (.clock, .wr_en(a_we), .wr_addr(a_wa),
      .wr_data(a_wd), .rd_addr(a_ra), .rd_data(a_rd));
   scc_ram #(.Width(32), .Depth(32)) u_trn (.clock, .wr_en(a_we), .wr_addr(t_wa),
      .wr_data(t_wd), .rd_addr(t_ra), .rd_data(t_rd));
   scc_ram #(.Width(11), .Depth(32)) u_stk (.clock, .wr_en(s_we), .wr_addr(s_wa),
      .wr_data(s_wd), .rd_addr(s_ra), .rd_data(s_rd));
   scc_ram #(.Width(5), .Depth(32)) u_fin (.clock, .wr_en(f_we), .wr_addr(f_wa),
      .wr_data(f_wd), .rd_addr(f_ra), .rd_data(f_rd));

   assign n = (vcount_ff == 6'd0) ? 6'd1 :
              (vcount_ff > 6'(scc_pkg::NumVertices)) ? 6'(scc_pkg::NumVertices) : vcount_ff;
   assign out_free  = !rv_ff || rsp_ready;
   assign emit_ok   = !pv_ff || out_free;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      live_mask = '0;
      for (int b = 0; b < 32; b++) live_mask[b] = (6'(b) < n);
   end

   // lowest unvisited live neighbour at or above the resume index
   always_comb begin
      row = pass2_ff ? t_rd : a_rd;
      cand = row & ~visited_ff & live_mask;
      found = 6'(scc_pkg::NumVertices);
      for (int b = 31; b >= 0; b--)
         if (cand[b] && 6'(b) >= top_j_ff) found = 6'(b);
   end

   // control and next state
   always_comb begin
      state_in = state_ff; ctr_in = ctr_ff; src_in = src_ff; dst_in = dst_ff;
      sp_in = sp_ff; fc_in = fc_ff; top_j_in = top_j_ff; top_v_in = top_v_ff;
      comp_in = comp_ff; pass2_in = pass2_ff; visited_in = visited_ff;
      pv_in = pv_ff; pend_in = pend_ff;
      rv_in = rv_ff && !rsp_ready; rsp_in = rsp_ff;
      a_we = 1'b0; a_wa = src_ff; a_wd = a_rd | (32'd1 << dst_ff);
      t_wa = dst_ff; t_wd = t_rd | (32'd1 << src_ff);
      a_ra = top_v_ff; t_ra = top_v_ff;
      s_we = 1'b0; s_wa = 5'(sp_ff - 6'd1); s_wd = {found + 6'd1, top_v_ff};
      s_ra = 5'(sp_ff - 6'd2);
      f_we = 1'b0; f_wa = fc_ff[4:0]; f_wd = top_v_ff; f_ra = 5'(ctr_ff - 6'd1);
      unique case (state_ff)
         S_IDLE: begin
            a_ra = req_data.source_vertex; t_ra = req_data.target_vertex;
            if (req_valid) begin
               src_in = req_data.source_vertex; dst_in = req_data.target_vertex;
               unique case (req_data.opcode)
                  scc_pkg::OpClear: begin ctr_in = '0; state_in = S_CLEAR; end
                  scc_pkg::OpAdd: begin
                     if ({1'b0, req_data.source_vertex} < n &&
                         {1'b0, req_data.target_vertex} < n)
                        state_in = S_ADDWR;
                  end
                  scc_pkg::OpRun: begin
                     visited_in = '0; fc_in = '0; ctr_in = '0; pass2_in = 1'b0;
                     comp_in = '0; state_in = S_ROOT1;
                  end
                  default: ;
               endcase
            end
         end
         S_CLEAR: begin
            a_we = 1'b1; a_wa = ctr_ff[4:0]; a_wd = '0; t_wa = ctr_ff[4:0]; t_wd = '0;
            ctr_in = ctr_ff + 6'd1;
            if (ctr_ff == 6'd31) state_in = S_IDLE;
         end
         S_ADDWR: begin a_we = 1'b1; state_in = S_IDLE; end
         // first pass roots in increasing index order
         S_ROOT1: begin
            if (ctr_ff >= n) begin
               pass2_in = 1'b1; visited_in = '0; ctr_in = fc_ff; state_in = S_ROOT2;
            end else if (visited_ff[ctr_ff[4:0]]) ctr_in = ctr_ff + 6'd1;
            else begin
               visited_in[ctr_ff[4:0]] = 1'b1;
               top_v_in = ctr_ff[4:0]; top_j_in = '0; sp_in = 6'd1;
               a_ra = ctr_ff[4:0]; t_ra = ctr_ff[4:0];
               ctr_in = ctr_ff + 6'd1; state_in = S_STEP;
            end
         end
         // row of the top is on the RAM output: descend or finish the top
         S_STEP: begin
            if (found < n) begin
               if (!pass2_ff || emit_ok) begin
                  s_we = 1'b1;
                  visited_in[found[4:0]] = 1'b1;
                  top_v_in = found[4:0]; top_j_in = '0; sp_in = sp_ff + 6'd1;
                  a_ra = found[4:0]; t_ra = found[4:0];
                  if (pass2_ff) begin
                     if (pv_ff) begin rv_in = 1'b1; rsp_in = pend_ff; end
                     pv_in = 1'b1;
                     pend_in = '{vertex: found[4:0], component: comp_ff,
                                 component_end: 1'b0, last: 1'b0};
                  end
               end
            end else begin
               if (!pass2_ff) begin f_we = 1'b1; fc_in = fc_ff + 6'd1; end
               if (sp_ff == 6'd1) begin
                  sp_in = '0;
                  if (pass2_ff) begin
                     pend_in.component_end = 1'b1;
                     comp_in = comp_ff + 5'd1;
                     state_in = S_ROOT2;
                  end else state_in = S_ROOT1;
               end else begin
                  sp_in = sp_ff - 6'd1; state_in = S_POP;
               end
            end
         end
         // parent entry is on the stack RAM output
         S_POP: begin
            top_v_in = s_rd[4:0]; top_j_in = s_rd[10:5];
            a_ra = s_rd[4:0]; t_ra = s_rd[4:0];
            state_in = S_STEP;
         end
         // second pass roots in decreasing finish time
         S_ROOT2: state_in = (ctr_ff == 6'd0) ? S_DONE : S_RCHK;
         S_RCHK: begin
            if (visited_ff[f_rd]) begin
               ctr_in = ctr_ff - 6'd1; state_in = S_ROOT2;
            end else if (emit_ok) begin
               visited_in[f_rd] = 1'b1;
               top_v_in = f_rd; top_j_in = '0; sp_in = 6'd1;
               a_ra = f_rd; t_ra = f_rd;
               ctr_in = ctr_ff - 6'd1;
               if (pv_ff) begin rv_in = 1'b1; rsp_in = pend_ff; end
               pv_in = 1'b1;
               pend_in = '{vertex: f_rd, component: comp_ff,
                           component_end: 1'b0, last: 1'b0};
               state_in = S_STEP;
            end
         end
         // release the held result as the final one
         S_DONE: begin
            if (out_free) begin
               rv_in = 1'b1; rsp_in = pend_ff; rsp_in.last = 1'b1;
               pv_in = 1'b0; pass2_in = 1'b0; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; ctr_ff <= '0; vcount_ff <= 6'(scc_pkg::NumVertices);
         rv_ff <= 1'b0; pv_ff <= 1'b0; sp_ff <= '0; fc_ff <= '0; comp_ff <= '0;
         pass2_ff <= 1'b0; visited_ff <= '0; top_v_ff <= '0; top_j_ff <= '0;
         src_ff <= '0; dst_ff <= '0;
      end else begin
         state_ff <= state_in; ctr_ff <= ctr_in; sp_ff <= sp_in; fc_ff <= fc_in;
         comp_ff <= comp_in; pass2_ff <= pass2_in; visited_ff <= visited_in;
         rv_ff <= rv_in; pv_ff <= pv_in; top_v_ff <= top_v_in; top_j_ff <= top_j_in;
         src_ff <= src_in; dst_ff <= dst_in;
         if (csr_wr_en) vcount_ff <= csr_wr_data;
      end
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
   end

   `ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, state_ff == S_IDLE)
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_data_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   `ASSERT_IMPL(a_sp_range, clock, reset, 1'b1, sp_ff <= 6'(scc_pkg::NumVertices))
endmodule
`default_nettype wire

// ----- sv/scc_ram.sv -----
// -----------------------------------------------------------------------------
// scc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// -----------------------------------------------------------------------------
`default_nettype none
module scc_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire
